// File: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: page table translation shared definitions
// Field widths, status codes, the register map and the structs that pass
// between the table and the top level.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int TABLE_SLOTS  = 8;
	localparam int SLOT_BITS    = $clog2(TABLE_SLOTS);
	localparam int ADDRESS_BITS = 32;
	localparam int PAGE_BITS    = 16;
	localparam int FRAME_BITS   = 16;
	localparam int PSIZE_BITS   = 17;
	localparam int STATUS_BITS  = 2;
	localparam int PADDR_BITS   = 3;
	localparam int PDATA_BITS   = 32;

	localparam int DIV_CNT_BITS = $clog2(ADDRESS_BITS + 1);
	localparam int MAC_CNT_BITS = $clog2(FRAME_BITS + 1);

	localparam logic [PSIZE_BITS-1:0] PAGE_SIZE_RESET = PSIZE_BITS'(4096);

	localparam logic [PADDR_BITS-3:0] REG_PAGE_SIZE = '0;

	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FAULT   = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd2;

	typedef struct packed {
		logic                  en;
		logic [SLOT_BITS-1:0]  slot;
		logic [PAGE_BITS-1:0]  page;
		logic                  valid;
		logic [FRAME_BITS-1:0] frame;
	} tbl_wr_t;

	typedef struct packed {
		logic                  done;
		logic                  found;
		logic                  valid;
		logic [FRAME_BITS-1:0] frame;
	} tbl_res_t;

endpackage

// File: src/ptt_divider.sv
// ----------------------------------------------------------------------------
// ptt_divider: bit-serial restoring divider
// Divides the logical address by the page size one quotient bit per cycle,
// giving the page number and the page offset.
// ----------------------------------------------------------------------------
module ptt_divider import ptt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ADDRESS_BITS-1:0] dividend,
	input  logic [PSIZE_BITS-1:0]   divisor,
	output logic                    done,
	output logic [ADDRESS_BITS-1:0] quotient,
	output logic [PSIZE_BITS-1:0]   remainder
);

	logic [ADDRESS_BITS-1:0] quo_q;
	logic [PSIZE_BITS-1:0]   rem_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    run_q;
	logic                    done_q;
	logic [PSIZE_BITS:0]     trial;
	logic [PSIZE_BITS:0]     diff;
	logic                    ge;

	assign trial = {rem_q, quo_q[ADDRESS_BITS-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(ADDRESS_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[ADDRESS_BITS-2:0], ge};
			rem_q <= ge ? diff[PSIZE_BITS-1:0] : trial[PSIZE_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: src/ptt_table.sv
// ----------------------------------------------------------------------------
// ptt_table: page table storage and slot scan
// Holds the table entries and searches the used slots for a page number,
// one slot per cycle from the lowest slot upward; a too-wide page misses.
// ----------------------------------------------------------------------------
module ptt_table import ptt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_wr_t              wr,
	input  logic                 lookup,
	input  logic [PAGE_BITS-1:0] page,
	input  logic                 wide,
	output tbl_res_t             res
);

	logic [PAGE_BITS-1:0]  slot_page_q  [TABLE_SLOTS];
	logic                  slot_valid_q [TABLE_SLOTS];
	logic [FRAME_BITS-1:0] slot_frame_q [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] slot_used_q;
	logic [SLOT_BITS-1:0]  idx_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic                  run_q;
	tbl_res_t              res_q;
	logic                  hit;

	assign hit = slot_used_q[idx_q] && (slot_page_q[idx_q] == page_q);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			slot_page_q[wr.slot]  <= wr.page;
			slot_valid_q[wr.slot] <= wr.valid;
			slot_frame_q[wr.slot] <= wr.frame;
		end
		if (lookup) begin
			page_q <= page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_used_q <= '0;
			run_q       <= 1'b0;
			idx_q       <= '0;
			res_q       <= '0;
		end else begin
			res_q.done <= 1'b0;
			if (wr.en) begin
				slot_used_q[wr.slot] <= 1'b1;
			end
			if (lookup) begin
				idx_q <= '0;
				if (wide) begin
					res_q.done  <= 1'b1;
					res_q.found <= 1'b0;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				if (hit) begin
					run_q       <= 1'b0;
					res_q.done  <= 1'b1;
					res_q.found <= 1'b1;
					res_q.valid <= slot_valid_q[idx_q];
					res_q.frame <= slot_frame_q[idx_q];
				end else if (idx_q == SLOT_BITS'(TABLE_SLOTS - 1)) begin
					run_q       <= 1'b0;
					res_q.done  <= 1'b1;
					res_q.found <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign res = res_q;

endmodule

// File: src/ptt_mac.sv
// ----------------------------------------------------------------------------
// ptt_mac: bit-serial multiply-add
// Forms frame times page size plus offset, taking one frame bit per cycle
// from the top, then adding the offset.
// ----------------------------------------------------------------------------
module ptt_mac import ptt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [FRAME_BITS-1:0]   frame,
	input  logic [PSIZE_BITS-1:0]   mcand,
	input  logic [PSIZE_BITS-1:0]   addend,
	output logic                    done,
	output logic [ADDRESS_BITS-1:0] product
);

	logic [FRAME_BITS-1:0]   frame_q;
	logic [ADDRESS_BITS-1:0] acc_q;
	logic [MAC_CNT_BITS-1:0] cnt_q;
	logic                    run_q;
	logic                    done_q;
	logic [ADDRESS_BITS-1:0] partial;

	assign partial = frame_q[FRAME_BITS-1] ? ADDRESS_BITS'(mcand) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == MAC_CNT_BITS'(FRAME_BITS)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			frame_q <= frame;
			acc_q   <= '0;
		end else if (run_q) begin
			if (cnt_q == MAC_CNT_BITS'(FRAME_BITS)) begin
				acc_q <= acc_q + ADDRESS_BITS'(addend);
			end else begin
				acc_q   <= {acc_q[ADDRESS_BITS-2:0], 1'b0} + partial;
				frame_q <= {frame_q[FRAME_BITS-2:0], 1'b0};
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// File: src/page_table_translate_top.sv
// ----------------------------------------------------------------------------
// page_table_translate_top: single-level page table with translation
// Top level with the command interface, the page size register and the
// sequencer that runs divide, slot scan and multiply-add in turn.
// ----------------------------------------------------------------------------
// A write command is taken and busy stays low. A translate command
// raises busy and returns its result after the bit-serial divider, the
// slot scan and the bit-serial multiply-add have run in turn. A miss or a
// page fault skips the multiply-add, and a page number too wide for any
// entry also skips the slot scan. The result is shown for one cycle with
// done high, and the receiver cannot stall it.
module page_table_translate_top import ptt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_BITS-1:0]   paddr,
	input  logic [PDATA_BITS-1:0]   pwdata,
	output logic [PDATA_BITS-1:0]   prdata,
	output logic                    pready,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  logic [SLOT_BITS-1:0]    entry_slot,
	input  logic [PAGE_BITS-1:0]    entry_page,
	input  logic                    entry_valid,
	input  logic [FRAME_BITS-1:0]   entry_frame,
	input  logic [ADDRESS_BITS-1:0] logical_address,
	output logic                    done,
	output logic [ADDRESS_BITS-1:0] physical_address,
	output logic [STATUS_BITS-1:0]  status
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_SCAN = 4'b0100,
		S_MUL  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [PSIZE_BITS-1:0]   page_size_q;
	logic [PSIZE_BITS-1:0]   dsize_q;
	logic                    done_q;
	logic [ADDRESS_BITS-1:0] phys_q;
	logic [STATUS_BITS-1:0]  status_q;
	logic                    reg_sel;
	logic                    accept;
	logic                    div_start;
	logic                    div_done;
	logic [ADDRESS_BITS-1:0] quotient;
	logic [PSIZE_BITS-1:0]   remainder;
	tbl_wr_t                 tbl_wr;
	tbl_res_t                tbl_res;
	logic                    mac_start;
	logic                    mac_done;
	logic [ADDRESS_BITS-1:0] product;

	assign reg_sel = paddr[PADDR_BITS-1:2] == REG_PAGE_SIZE;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_BITS'(page_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= PAGE_SIZE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			page_size_q <= pwdata[PSIZE_BITS-1:0];
		end
	end

	assign accept    = start && !busy;
	assign div_start = accept && (command == CMD_TRANSLATE);
	assign mac_start = (state_q == S_SCAN) && tbl_res.done && tbl_res.found && tbl_res.valid;

	assign tbl_wr.en    = accept && (command == CMD_WRITE);
	assign tbl_wr.slot  = entry_slot;
	assign tbl_wr.page  = entry_page;
	assign tbl_wr.valid = entry_valid;
	assign tbl_wr.frame = entry_frame;

	always_ff @(posedge clk) begin
		if (div_start) begin
			dsize_q <= (page_size_q == '0) ? PSIZE_BITS'(1) : page_size_q;
		end
	end

	ptt_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (logical_address),
		.divisor   (dsize_q),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	ptt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.lookup (div_done),
		.page   (quotient[PAGE_BITS-1:0]),
		.wide   (|quotient[ADDRESS_BITS-1:PAGE_BITS]),
		.res    (tbl_res)
	);

	ptt_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mac_start),
		.frame   (tbl_res.frame),
		.mcand   (dsize_q),
		.addend  (remainder),
		.done    (mac_done),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tbl_res.done) begin
						if (mac_start) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_MUL: begin
					if (mac_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && tbl_res.done && !mac_start) begin
			phys_q   <= '0;
			status_q <= tbl_res.found ? ST_FAULT : ST_MISSING;
		end else if ((state_q == S_MUL) && mac_done) begin
			phys_q   <= product;
			status_q <= ST_OK;
		end
	end

	assign busy             = state_q != S_IDLE;
	assign done             = done_q;
	assign physical_address = phys_q;
	assign status           = status_q;

endmodule

// File: src/ptt_checker.sv
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks for the page table translation block
// Watches the command and result ports over time and is bound to the top.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    command,
	input logic                    done,
	input logic [ADDRESS_BITS-1:0] physical_address,
	input logic [STATUS_BITS-1:0]  status
);

	// A translate request keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_TRANSLATE) |=> busy)
		else $error("translate request did not raise busy");

	// A write request finishes at once and leaves the block free.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_WRITE) |=> !busy)
		else $error("write request left the block busy");

	// Every result follows a cycle in which a translation was running.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a translation in progress");

	// A failed translation returns a zero address.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (physical_address == '0))
		else $error("nonzero address on a failed translation");

	// Results never come back to back.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results in consecutive cycles");

endmodule

bind page_table_translate_top ptt_checker u_ptt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.command          (command),
	.done             (done),
	.physical_address (physical_address),
	.status           (status)
);
